@@ rtl/substring_hash_compare_assert.svh @@
// ---------------------------------------------------------------------------
// substring_hash_compare assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef SUBSTRING_HASH_COMPARE_ASSERT_SVH
`define SUBSTRING_HASH_COMPARE_ASSERT_SVH

// same-cycle implication
`define SHC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("substring_hash_compare: assertion failed");

// next-cycle implication
`define SHC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("substring_hash_compare: assertion failed");

`endif

@@ rtl/shc_pkg.sv @@
// ---------------------------------------------------------------------------
// shc_pkg
// Constants, codes and shared types of the substring hash compare block.
// ---------------------------------------------------------------------------
package shc_pkg;

    localparam int MAX_LEN     = 4096;
    localparam int ADDR_W      = $clog2(MAX_LEN);
    localparam int LEN_W       = ADDR_W + 1;
    localparam int CHAR_W      = 8;
    localparam int HASH_W      = 14;
    localparam int REM_W       = HASH_W + 1;
    localparam int PROD_W      = 2 * HASH_W;
    localparam int RECIP_SHIFT = 40;
    localparam int RECIP_W     = 27;
    localparam int EST_W       = PROD_W + RECIP_W;
    localparam int QUOT_W      = EST_W - RECIP_SHIFT;

    localparam logic [HASH_W-1:0]  HASH_MOD     = 14'd10007;
    localparam logic [HASH_W-1:0]  HASH_BASE    = 14'd13;
    localparam logic [HASH_W-1:0]  BASE_INVERSE = 14'd6928;
    localparam logic [RECIP_W-1:0] RECIP        =
        RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd10007);

    typedef enum logic [1:0] {
        OP_APPEND  = 2'd0,
        OP_COMPARE = 2'd1,
        OP_CLEAR   = 2'd2,
        OP_NOP     = 2'd3
    } shc_op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_RANGE = 2'd1,
        ST_FULL      = 2'd2
    } shc_status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_A_POW_GO,
        S_A_POW_WT,
        S_A_INV_GO,
        S_A_INV_WT,
        S_A_CHR_GO,
        S_A_CHR_WT,
        S_Q_RD_HI,
        S_Q_RD_LO,
        S_Q_SUB,
        S_Q_MUL_GO,
        S_Q_MUL_WT,
        S_CMP,
        S_DONE
    } shc_state_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [CHAR_W-1:0] chr;
        logic [HASH_W-1:0] hash;
        logic [HASH_W-1:0] inv;
    } shc_wr_t;

    typedef struct packed {
        logic [ADDR_W-1:0] hash_addr;
        logic [ADDR_W-1:0] inv_addr;
        logic [ADDR_W-1:0] chr_addr_a;
        logic [ADDR_W-1:0] chr_addr_b;
    } shc_rd_t;

    typedef struct packed {
        logic [HASH_W-1:0] hash;
        logic [HASH_W-1:0] inv;
        logic [CHAR_W-1:0] chr_a;
        logic [CHAR_W-1:0] chr_b;
    } shc_rdata_t;

endpackage

@@ rtl/substring_hash_compare.sv @@
// ---------------------------------------------------------------------------
// substring_hash_compare
// String store with rolling polynomial hashes (base 13, modulo 10007) and
// range equality queries confirmed character by character.
// ---------------------------------------------------------------------------
// Command channel: a transfer happens at a rising edge with start high and
// busy low; opcode selects append, compare or clear, the other fields
// carry the character and the two one-based inclusive ranges.
// Result channel: done is high for exactly one cycle with status, same,
// hash_a and hash_b valid; the receiver takes it in that cycle and cannot
// hold it off. busy stays high from the transfer until the done cycle.
// Sequence: clear, unused opcode, full store and bad range go straight to
// done. An append runs three chained products through the four-stage
// modular multiplier. A query computes two range hashes through the same
// multiplier and, when lengths and hashes agree, compares the character
// pairs in order, stopping at the first differing pair, read through the
// two read ports of the character store.
// A new command is taken in the cycle after done.
// Reset: the string is emptied; memory contents are kept and never read
// beyond the current length, so no clearing pass runs.
// ---------------------------------------------------------------------------
module substring_hash_compare
    import shc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        opcode,
    input  logic [CHAR_W-1:0] char_code,
    input  logic [LEN_W-1:0]  left_a,
    input  logic [LEN_W-1:0]  right_a,
    input  logic [LEN_W-1:0]  left_b,
    input  logic [LEN_W-1:0]  right_b,
    output logic              done,
    output logic [1:0]        status,
    output logic              same,
    output logic [HASH_W-1:0] hash_a,
    output logic [HASH_W-1:0] hash_b
);

    logic              mul_go;
    logic [HASH_W-1:0] mul_a;
    logic [HASH_W-1:0] mul_b;
    logic              mul_valid;
    logic [HASH_W-1:0] mul_res;
    shc_wr_t           wr;
    shc_rd_t           rd;
    shc_rdata_t        rdata;

    shc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .opcode    (opcode),
        .char_code (char_code),
        .left_a    (left_a),
        .right_a   (right_a),
        .left_b    (left_b),
        .right_b   (right_b),
        .busy      (busy),
        .done      (done),
        .status    (status),
        .same      (same),
        .hash_a    (hash_a),
        .hash_b    (hash_b),
        .mul_go    (mul_go),
        .mul_a     (mul_a),
        .mul_b     (mul_b),
        .mul_valid (mul_valid),
        .mul_res   (mul_res),
        .wr        (wr),
        .rd        (rd),
        .rdata     (rdata)
    );

    shc_mulmod u_mulmod (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (mul_go),
        .a         (mul_a),
        .b         (mul_b),
        .res_valid (mul_valid),
        .res       (mul_res)
    );

    shc_store u_store (
        .clk   (clk),
        .wr    (wr),
        .rd    (rd),
        .rdata (rdata)
    );

endmodule

@@ rtl/shc_mulmod.sv @@
// ---------------------------------------------------------------------------
// shc_mulmod
// Pipelined modular multiplier: (a * b) mod 10007 in four stages, reduction
// by reciprocal multiplication and one corrective subtract.
// ---------------------------------------------------------------------------
module shc_mulmod
    import shc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              go,
    input  logic [HASH_W-1:0] a,
    input  logic [HASH_W-1:0] b,
    output logic              res_valid,
    output logic [HASH_W-1:0] res
);

    logic [3:0]        vld_reg;
    logic [3:0]        vld_next;
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod2_reg;
    logic [QUOT_W-1:0] quot_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [HASH_W-1:0] res_reg;
    logic [EST_W-1:0]  est;
    logic [PROD_W-1:0] sub_val;
    logic [REM_W-1:0]  rem_fix;

    assign vld_next = {vld_reg[2:0], go};
    assign est      = EST_W'(prod_reg) * EST_W'(RECIP);
    assign sub_val  = prod2_reg - PROD_W'(quot_reg) * PROD_W'(HASH_MOD);
    assign rem_fix  = (rem_reg >= REM_W'(HASH_MOD)) ? rem_reg - REM_W'(HASH_MOD) : rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= PROD_W'(a) * PROD_W'(b);
        prod2_reg <= prod_reg;
        quot_reg  <= est[EST_W-1:RECIP_SHIFT];
        rem_reg   <= sub_val[REM_W-1:0];
        res_reg   <= rem_fix[HASH_W-1:0];
    end

    assign res_valid = vld_reg[3];
    assign res       = res_reg;

endmodule

@@ rtl/shc_store.sv @@
// ---------------------------------------------------------------------------
// shc_store
// String, prefix hash and inverse power memories; entry p of the string
// lives at address p - 1. One shared write port, registered reads.
// ---------------------------------------------------------------------------
module shc_store
    import shc_pkg::*;
(
    input  logic       clk,
    input  shc_wr_t    wr,
    input  shc_rd_t    rd,
    output shc_rdata_t rdata
);

    logic [CHAR_W-1:0] char_mem [MAX_LEN];
    logic [HASH_W-1:0] hash_mem [MAX_LEN];
    logic [HASH_W-1:0] inv_mem  [MAX_LEN];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            char_mem[wr.addr] <= wr.chr;
            hash_mem[wr.addr] <= wr.hash;
            inv_mem[wr.addr]  <= wr.inv;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata.hash  <= hash_mem[rd.hash_addr];
        rdata.inv   <= inv_mem[rd.inv_addr];
        rdata.chr_a <= char_mem[rd.chr_addr_a];
        rdata.chr_b <= char_mem[rd.chr_addr_b];
    end

endmodule

@@ rtl/shc_ctrl.sv @@
// ---------------------------------------------------------------------------
// shc_ctrl
// Sequencer: decodes commands, drives the shared modular multiplier,
// updates the stores and walks the character check.
// ---------------------------------------------------------------------------
`include "substring_hash_compare_assert.svh"

module shc_ctrl
    import shc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [1:0]        opcode,
    input  logic [CHAR_W-1:0] char_code,
    input  logic [LEN_W-1:0]  left_a,
    input  logic [LEN_W-1:0]  right_a,
    input  logic [LEN_W-1:0]  left_b,
    input  logic [LEN_W-1:0]  right_b,
    output logic              busy,
    output logic              done,
    output logic [1:0]        status,
    output logic              same,
    output logic [HASH_W-1:0] hash_a,
    output logic [HASH_W-1:0] hash_b,
    output logic              mul_go,
    output logic [HASH_W-1:0] mul_a,
    output logic [HASH_W-1:0] mul_b,
    input  logic              mul_valid,
    input  logic [HASH_W-1:0] mul_res,
    output shc_wr_t           wr,
    output shc_rd_t           rd,
    input  shc_rdata_t        rdata
);

    shc_state_t        state_reg,  state_next;
    logic [LEN_W-1:0]  len_reg,    len_next;
    logic [HASH_W-1:0] pow_reg,    pow_next;
    logic [HASH_W-1:0] inv_reg,    inv_next;
    logic [HASH_W-1:0] hsh_reg,    hsh_next;
    logic [HASH_W-1:0] pow_t_reg,  pow_t_next;
    logic [HASH_W-1:0] inv_t_reg,  inv_t_next;
    logic [HASH_W-1:0] hi_reg,     hi_next;
    logic [HASH_W-1:0] diff_reg,   diff_next;
    logic [CHAR_W-1:0] chr_reg,    chr_next;
    logic [LEN_W-1:0]  la_reg,     la_next;
    logic [LEN_W-1:0]  ra_reg,     ra_next;
    logic [LEN_W-1:0]  lb_reg,     lb_next;
    logic [LEN_W-1:0]  rb_reg,     rb_next;
    logic              side_reg,   side_next;
    logic [LEN_W-1:0]  idx_reg,    idx_next;
    logic              pend_reg,   pend_next;
    shc_status_t       st_reg,     st_next;
    logic              same_reg,   same_next;
    logic [HASH_W-1:0] ha_reg,     ha_next;
    logic [HASH_W-1:0] hb_reg,     hb_next;

    shc_op_t           op_in;
    logic              accept;
    logic              ok_a;
    logic              ok_b;
    logic [LEN_W-1:0]  cur_l;
    logic [LEN_W-1:0]  cur_r;
    logic [LEN_W-1:0]  hi_idx;
    logic [LEN_W-1:0]  lo_idx;
    logic [LEN_W-1:0]  inv_idx;
    logic [LEN_W-1:0]  pos_a;
    logic [LEN_W-1:0]  pos_b;
    logic [LEN_W-1:0]  cnt_a;
    logic [LEN_W-1:0]  cnt_b;
    logic [HASH_W-1:0] lo_hash;
    logic [REM_W-1:0]  diff_raw;
    logic [REM_W-1:0]  diff_fix;
    logic [REM_W-1:0]  sum_raw;
    logic [REM_W-1:0]  sum_fix;
    logic              match;
    logic              issue;
    logic              chr_eq;

    assign op_in  = shc_op_t'(opcode);
    assign accept = start && (state_reg == S_IDLE);
    assign ok_a   = (left_a != '0) && (right_a >= left_a) && (right_a <= len_reg);
    assign ok_b   = (left_b != '0) && (right_b >= left_b) && (right_b <= len_reg);

    assign cur_l   = side_reg ? lb_reg : la_reg;
    assign cur_r   = side_reg ? rb_reg : ra_reg;
    assign hi_idx  = cur_r - LEN_W'(1);
    assign lo_idx  = cur_l - LEN_W'(2);
    assign inv_idx = cur_l - LEN_W'(1);
    assign pos_a   = la_reg - LEN_W'(1) + idx_reg;
    assign pos_b   = lb_reg - LEN_W'(1) + idx_reg;
    assign cnt_a   = ra_reg - la_reg + LEN_W'(1);
    assign cnt_b   = rb_reg - lb_reg + LEN_W'(1);

    assign lo_hash  = (cur_l == LEN_W'(1)) ? '0 : rdata.hash;
    assign diff_raw = REM_W'(hi_reg) + REM_W'(HASH_MOD) - REM_W'(lo_hash);
    assign diff_fix = (diff_raw >= REM_W'(HASH_MOD)) ? diff_raw - REM_W'(HASH_MOD) : diff_raw;
    assign sum_raw  = REM_W'(hsh_reg) + REM_W'(mul_res);
    assign sum_fix  = (sum_raw >= REM_W'(HASH_MOD)) ? sum_raw - REM_W'(HASH_MOD) : sum_raw;

    assign match  = (cnt_a == cnt_b) && (ha_reg == mul_res);
    assign issue  = (state_reg == S_CMP) && (idx_reg < cnt_a);
    assign chr_eq = (rdata.chr_a == rdata.chr_b);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (op_in)
                        OP_APPEND:  state_next = (len_reg == LEN_W'(MAX_LEN)) ? S_DONE
                                                                                 : S_A_POW_GO;
                        OP_COMPARE: state_next = (ok_a && ok_b) ? S_Q_RD_HI : S_DONE;
                        default:    state_next = S_DONE;
                    endcase
                end
            end
            S_A_POW_GO: state_next = S_A_POW_WT;
            S_A_POW_WT: state_next = mul_valid ? S_A_INV_GO : S_A_POW_WT;
            S_A_INV_GO: state_next = S_A_INV_WT;
            S_A_INV_WT: state_next = mul_valid ? S_A_CHR_GO : S_A_INV_WT;
            S_A_CHR_GO: state_next = S_A_CHR_WT;
            S_A_CHR_WT: state_next = mul_valid ? S_DONE : S_A_CHR_WT;
            S_Q_RD_HI:  state_next = S_Q_RD_LO;
            S_Q_RD_LO:  state_next = S_Q_SUB;
            S_Q_SUB:    state_next = S_Q_MUL_GO;
            S_Q_MUL_GO: state_next = S_Q_MUL_WT;
            S_Q_MUL_WT:
            begin
                if (mul_valid)
                begin
                    if (!side_reg)
                    begin
                        state_next = S_Q_RD_HI;
                    end
                    else
                    begin
                        state_next = match ? S_CMP : S_DONE;
                    end
                end
            end
            S_CMP:
            begin
                if (pend_reg && (!chr_eq || (idx_reg == cnt_a)))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:     state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        busy          = (state_reg != S_IDLE);
        done          = (state_reg == S_DONE);
        mul_go        = 1'b0;
        mul_a         = diff_reg;
        mul_b         = inv_t_reg;
        wr.en         = (state_reg == S_A_CHR_WT) && mul_valid;
        wr.addr       = len_reg[ADDR_W-1:0];
        wr.chr        = chr_reg;
        wr.hash       = sum_fix[HASH_W-1:0];
        wr.inv        = inv_t_reg;
        rd.hash_addr  = (state_reg == S_Q_RD_HI) ? hi_idx[ADDR_W-1:0] : lo_idx[ADDR_W-1:0];
        rd.inv_addr   = inv_idx[ADDR_W-1:0];
        rd.chr_addr_a = pos_a[ADDR_W-1:0];
        rd.chr_addr_b = pos_b[ADDR_W-1:0];
        case (state_reg)
            S_A_POW_GO:
            begin
                mul_go = 1'b1;
                mul_a  = pow_reg;
                mul_b  = HASH_BASE;
            end
            S_A_INV_GO:
            begin
                mul_go = 1'b1;
                mul_a  = inv_reg;
                mul_b  = BASE_INVERSE;
            end
            S_A_CHR_GO:
            begin
                mul_go = 1'b1;
                mul_a  = pow_t_reg;
                mul_b  = HASH_W'(chr_reg);
            end
            S_Q_MUL_GO:
            begin
                mul_go = 1'b1;
            end
            default:
            begin
                mul_go = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        len_next   = len_reg;
        pow_next   = pow_reg;
        inv_next   = inv_reg;
        hsh_next   = hsh_reg;
        pow_t_next = pow_t_reg;
        inv_t_next = inv_t_reg;
        hi_next    = hi_reg;
        diff_next  = diff_reg;
        chr_next   = chr_reg;
        la_next    = la_reg;
        ra_next    = ra_reg;
        lb_next    = lb_reg;
        rb_next    = rb_reg;
        side_next  = side_reg;
        idx_next   = idx_reg;
        pend_next  = 1'b0;
        st_next    = st_reg;
        same_next  = same_reg;
        ha_next    = ha_reg;
        hb_next    = hb_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    chr_next  = char_code;
                    la_next   = left_a;
                    ra_next   = right_a;
                    lb_next   = left_b;
                    rb_next   = right_b;
                    side_next = 1'b0;
                    st_next   = ST_OK;
                    same_next = 1'b0;
                    ha_next   = '0;
                    hb_next   = '0;
                    case (op_in)
                        OP_APPEND:
                        begin
                            if (len_reg == LEN_W'(MAX_LEN))
                            begin
                                st_next = ST_FULL;
                            end
                        end
                        OP_COMPARE:
                        begin
                            if (!(ok_a && ok_b))
                            begin
                                st_next = ST_BAD_RANGE;
                            end
                        end
                        OP_CLEAR:
                        begin
                            len_next = '0;
                            pow_next = HASH_W'(1);
                            inv_next = HASH_W'(1);
                            hsh_next = '0;
                        end
                        default:
                        begin
                            st_next = ST_OK;
                        end
                    endcase
                end
            end
            S_A_POW_WT:
            begin
                if (mul_valid)
                begin
                    pow_t_next = mul_res;
                end
            end
            S_A_INV_WT:
            begin
                if (mul_valid)
                begin
                    inv_t_next = mul_res;
                end
            end
            S_A_CHR_WT:
            begin
                if (mul_valid)
                begin
                    pow_next = pow_t_reg;
                    inv_next = inv_t_reg;
                    hsh_next = sum_fix[HASH_W-1:0];
                    len_next = len_reg + LEN_W'(1);
                end
            end
            S_Q_RD_LO:
            begin
                hi_next    = rdata.hash;
                inv_t_next = rdata.inv;
            end
            S_Q_SUB:
            begin
                diff_next = diff_fix[HASH_W-1:0];
            end
            S_Q_MUL_WT:
            begin
                if (mul_valid)
                begin
                    if (!side_reg)
                    begin
                        ha_next   = mul_res;
                        side_next = 1'b1;
                    end
                    else
                    begin
                        hb_next  = mul_res;
                        idx_next = '0;
                    end
                end
            end
            S_CMP:
            begin
                pend_next = issue;
                if (issue)
                begin
                    idx_next = idx_reg + LEN_W'(1);
                end
                if (pend_reg && chr_eq && (idx_reg == cnt_a))
                begin
                    same_next = 1'b1;
                end
            end
            default:
            begin
                pend_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            len_reg   <= '0;
            pow_reg   <= HASH_W'(1);
            inv_reg   <= HASH_W'(1);
            hsh_reg   <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            pow_reg   <= pow_next;
            inv_reg   <= inv_next;
            hsh_reg   <= hsh_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pow_t_reg <= pow_t_next;
        inv_t_reg <= inv_t_next;
        hi_reg    <= hi_next;
        diff_reg  <= diff_next;
        chr_reg   <= chr_next;
        la_reg    <= la_next;
        ra_reg    <= ra_next;
        lb_reg    <= lb_next;
        rb_reg    <= rb_next;
        side_reg  <= side_next;
        idx_reg   <= idx_next;
        st_reg    <= st_next;
        same_reg  <= same_next;
        ha_reg    <= ha_next;
        hb_reg    <= hb_next;
    end

    assign status = st_reg;
    assign same   = same_reg;
    assign hash_a = ha_reg;
    assign hash_b = hb_reg;

    `SHC_ASSERT_NEXT(a_done_single, done, !done)
    `SHC_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `SHC_ASSERT_NOW(a_len_bound, 1'b1, len_reg <= LEN_W'(MAX_LEN))
    `SHC_ASSERT_NOW(a_mul_reduced, mul_valid, mul_res < HASH_MOD)
    `SHC_ASSERT_NOW(a_mul_expected, mul_valid,
        state_reg == S_A_POW_WT || state_reg == S_A_INV_WT ||
        state_reg == S_A_CHR_WT || state_reg == S_Q_MUL_WT)
    `SHC_ASSERT_NOW(a_same_clean, done && same, st_reg == ST_OK && ha_reg == hb_reg)

endmodule
